[rtl/trcl_pkg.sv]
`default_nettype none
package trcl_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [1:0] CFG_MIN_REGION   = 2'd1;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd3;

  localparam logic [7:0]  RST_THRESHOLD    = 8'd3;
  localparam logic [15:0] RST_MIN_REGION   = 16'd100;
  localparam logic [8:0]  RST_FRAME_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd256;

  localparam logic [9:0] REGION_COUNT_MAX = 10'd1023;
  localparam logic [7:0] LABEL_MAX        = 8'd255;

  typedef struct packed {
    logic       start;
    logic [1:0] cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pixel_value;
  } req_t;

  typedef struct packed {
    logic [7:0]  threshold;
    logic [15:0] min_region;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/trcl_join.sv]
`default_nettype none
module trcl_join
(
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [7:0] threshold,
  output logic            join_ok
);

  logic [7:0] diff;

  always_comb begin
    diff    = (a > b) ? (a - b) : (b - a);
    join_ok = (diff <= threshold);
  end

endmodule
`default_nettype wire

[rtl/trcl_engine.sv]
`default_nettype none
module trcl_engine
  import trcl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int XW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9,
  localparam int XH = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9
)
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire req_t          req,
  input  wire cfg_t          cfg,
  input  wire logic [XW-1:0] w_eff,
  input  wire logic [XH-1:0] h_eff,
  output logic               busy,
  output logic               done,
  output logic [7:0]         label,
  output logic [9:0]         region_count
);

  localparam int AW    = RW + CW;
  localparam int SW    = AW + 1;
  localparam int DEPTH = 1 << AW;
  localparam int MW    = (SW > 16) ? SW : 16;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_POPW  = 4'd6;
  localparam logic [3:0] S_CEN   = 4'd7;
  localparam logic [3:0] S_NB    = 4'd8;
  localparam logic [3:0] S_NBCHK = 4'd9;
  localparam logic [3:0] S_FSW   = 4'd10;
  localparam logic [3:0] S_FWR   = 4'd11;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  logic [7:0] img_mem   [DEPTH];
  logic [7:0] lab_mem   [DEPTH];
  logic       rej_mem   [DEPTH];
  logic       trial_mem [DEPTH];
  logic [AW-1:0] stk_mem [DEPTH];

  logic [7:0]    img_rd;
  logic [7:0]    lab_rd;
  logic          rej_rd;
  logic          trial_rd;
  logic [AW-1:0] stk_rd;

  logic [3:0]    state;
  logic [SW-1:0] clr;
  logic          run_pend;
  logic [RW-1:0] scan_r;
  logic [CW-1:0] scan_c;
  logic [AW-1:0] p;
  logic [7:0]    a;
  logic [1:0]    nb;
  logic [SW-1:0] size;
  logic [SW-1:0] head;
  logic [SW-1:0] k;
  logic          big;
  logic          rd_in;
  logic [7:0]    next_label;
  logic [9:0]    regions_found;
  logic [7:0]    label_r;
  logic          done_r;

  logic [XH-1:0] req_rx;
  logic [XW-1:0] req_cx;
  logic [AW-1:0] req_a;
  logic [AW-1:0] scan_a;
  logic [RW-1:0] p_r;
  logic [CW-1:0] p_c;
  logic [RW-1:0] q_r;
  logic [CW-1:0] q_c;
  logic [AW-1:0] q;
  logic          nb_ok;
  logic          join_ok;
  logic          col_more;
  logic          row_more;
  logic          load_ok;
  logic          read_ok;
  logic          accept;

  logic          img_we;
  logic [AW-1:0] img_ra;
  logic          lab_we;
  logic [7:0]    lab_wd;
  logic [AW-1:0] lab_wa;
  logic          rej_we;
  logic          rej_wd;
  logic [AW-1:0] rej_wa;
  logic          trial_we;
  logic          trial_wd;
  logic [AW-1:0] trial_wa;
  logic          stk_we;
  logic [AW-1:0] stk_wa;
  logic [AW-1:0] stk_wd;
  logic [AW-1:0] stk_ra;
  logic [AW-1:0] rd_a;

  trcl_join u_join (
    .a         (a),
    .b         (img_rd),
    .threshold (cfg.threshold),
    .join_ok   (join_ok)
  );

  always_comb begin
    req_rx   = XH'(req.row);
    req_cx   = XW'(req.col);
    req_a    = {req_rx[RW-1:0], req_cx[CW-1:0]};
    load_ok  = (req_rx < XH'(MAX_HEIGHT)) && (req_cx < XW'(MAX_WIDTH));
    read_ok  = (req_rx < h_eff) && (req_cx < w_eff);
    accept   = req.start && (state == S_IDLE);
    scan_a   = {scan_r, scan_c};
    col_more = (XW'(scan_c) + XW'(1)) < w_eff;
    row_more = (XH'(scan_r) + XH'(1)) < h_eff;
    p_r      = p[AW-1:CW];
    p_c      = p[CW-1:0];
    q_r      = p_r;
    q_c      = p_c;
    nb_ok    = 1'b0;
    unique case (nb)
      NB_UP: begin
        q_r   = p_r - RW'(1);
        nb_ok = (p_r != '0);
      end
      NB_DOWN: begin
        q_r   = p_r + RW'(1);
        nb_ok = (XH'(p_r) + XH'(1)) < h_eff;
      end
      NB_LEFT: begin
        q_c   = p_c - CW'(1);
        nb_ok = (p_c != '0);
      end
      NB_RIGHT: begin
        q_c   = p_c + CW'(1);
        nb_ok = (XW'(p_c) + XW'(1)) < w_eff;
      end
    endcase
    q = {q_r, q_c};
  end

  always_comb begin
    img_we   = accept && (req.cmd == CMD_LOAD) && load_ok;
    img_ra   = (state == S_POPW) ? stk_rd : q;
    lab_we   = 1'b0;
    lab_wd   = '0;
    lab_wa   = clr[AW-1:0];
    rej_we   = 1'b0;
    rej_wd   = 1'b0;
    rej_wa   = clr[AW-1:0];
    trial_we = 1'b0;
    trial_wd = 1'b0;
    trial_wa = clr[AW-1:0];
    stk_we   = 1'b0;
    stk_wa   = size[AW-1:0];
    stk_wd   = q;
    stk_ra   = (state == S_POP) ? head[AW-1:0] : k[AW-1:0];
    rd_a     = (state == S_IDLE) ? req_a : scan_a;
    unique case (state)
      S_CLEAR: begin
        lab_we   = 1'b1;
        rej_we   = 1'b1;
        trial_we = 1'b1;
      end
      S_CHK: begin
        if (lab_rd == '0 && !rej_rd) begin
          trial_we = 1'b1;
          trial_wd = 1'b1;
          trial_wa = scan_a;
          stk_we   = 1'b1;
          stk_wa   = '0;
          stk_wd   = scan_a;
        end
      end
      S_NBCHK: begin
        if (!trial_rd && join_ok) begin
          trial_we = 1'b1;
          trial_wd = 1'b1;
          trial_wa = q;
          stk_we   = 1'b1;
        end
      end
      S_FWR: begin
        trial_we = 1'b1;
        trial_wa = stk_rd;
        lab_wa   = stk_rd;
        rej_wa   = stk_rd;
        lab_wd   = next_label;
        rej_wd   = 1'b1;
        lab_we   = big;
        rej_we   = !big;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[req_a] <= req.pixel_value;
    end
    img_rd <= img_mem[img_ra];
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_wa] <= lab_wd;
    end
    lab_rd <= lab_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (rej_we) begin
      rej_mem[rej_wa] <= rej_wd;
    end
    rej_rd <= rej_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (trial_we) begin
      trial_mem[trial_wa] <= trial_wd;
    end
    trial_rd <= trial_mem[q];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      run_pend      <= 1'b0;
      nb            <= NB_UP;
      next_label    <= 8'd1;
      regions_found <= '0;
      done_r        <= 1'b0;
      label_r       <= '0;
    end else begin
      done_r  <= 1'b0;
      label_r <= '0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + SW'(1);
          if (clr == SW'(DEPTH - 1)) begin
            scan_r <= '0;
            scan_c <= '0;
            if (run_pend) begin
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req.start) begin
            unique case (req.cmd)
              CMD_RUN: begin
                clr           <= '0;
                run_pend      <= 1'b1;
                next_label    <= 8'd1;
                regions_found <= '0;
                state         <= S_CLEAR;
              end
              CMD_READ: begin
                rd_in <= read_ok;
                state <= S_READ;
              end
              CMD_LOAD, CMD_NOP: begin
                done_r <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          done_r  <= 1'b1;
          label_r <= rd_in ? lab_rd : '0;
          state   <= S_IDLE;
        end
        S_SCAN: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (lab_rd == '0 && !rej_rd) begin
            size  <= SW'(1);
            head  <= '0;
            state <= S_POP;
          end else if (col_more) begin
            scan_c <= scan_c + CW'(1);
            state  <= S_SCAN;
          end else if (row_more) begin
            scan_c <= '0;
            scan_r <= scan_r + RW'(1);
            state  <= S_SCAN;
          end else begin
            done_r   <= 1'b1;
            run_pend <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_POP: begin
          if (head == size) begin
            k     <= '0;
            big   <= MW'(size) > MW'(cfg.min_region);
            state <= S_FSW;
          end else begin
            head  <= head + SW'(1);
            state <= S_POPW;
          end
        end
        S_POPW: begin
          p     <= stk_rd;
          state <= S_CEN;
        end
        S_CEN: begin
          a     <= img_rd;
          nb    <= NB_UP;
          state <= S_NB;
        end
        S_NB: begin
          if (nb_ok) begin
            state <= S_NBCHK;
          end else if (nb == NB_RIGHT) begin
            state <= S_POP;
          end else begin
            nb <= nb + 2'd1;
          end
        end
        S_NBCHK: begin
          if (!trial_rd && join_ok) begin
            size <= size + SW'(1);
          end
          if (nb == NB_RIGHT) begin
            state <= S_POP;
          end else begin
            nb    <= nb + 2'd1;
            state <= S_NB;
          end
        end
        S_FSW: begin
          if (k == size) begin
            if (big) begin
              if (regions_found != REGION_COUNT_MAX) begin
                regions_found <= regions_found + 10'd1;
              end
              if (next_label != LABEL_MAX) begin
                next_label <= next_label + 8'd1;
              end
            end
            state <= S_CHK;
          end else begin
            state <= S_FWR;
          end
        end
        S_FWR: begin
          k     <= k + SW'(1);
          state <= S_FSW;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign done         = done_r;
  assign label        = label_r;
  assign region_count = regions_found;

endmodule
`default_nettype wire

[rtl/threshold_connected_region_labeling_top.sv]
// Channel   Ports                                      Transaction
// command   start, busy, cmd, row, col, pixel_value    start high while busy low
// result    done, label, region_count, label_saturated done high for one cycle
// config    cfg_we, cfg_index, cfg_data                cfg_we high, no wait
//
// Load and no-operation commands give their result in the cycle after they are taken, one per cycle.
// A read passes through the S_READ state and the registered read of the label memory.
// A run first clears the label and mark memories, one entry per cycle
// (all 2**(clog2(MAX_HEIGHT)+clog2(MAX_WIDTH)) entries, 65536 by default), then visits
// each scanned pixel in S_SCAN and S_CHK, checks each in-frame neighbour of each region
// pixel and writes each region pixel's label or mark, all through one memory port per store.
// After reset the same clearing pass runs with busy high. Results cannot stall.
`default_nettype none
module threshold_connected_region_labeling_top
  import trcl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  row,
  input  wire logic [7:0]  col,
  input  wire logic [7:0]  pixel_value,
  output logic             done,
  output logic [7:0]       label,
  output logic [9:0]       region_count,
  output logic             label_saturated,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int XW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int XH = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;

  logic [7:0]    threshold;
  logic [15:0]   min_region;
  logic [8:0]    frame_width;
  logic [8:0]    frame_height;
  logic [XW-1:0] fw_x;
  logic [XH-1:0] fh_x;
  logic [XW-1:0] w_eff;
  logic [XH-1:0] h_eff;
  req_t          req;
  cfg_t          cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= RST_THRESHOLD;
      min_region   <= RST_MIN_REGION;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:    threshold    <= cfg_data[7:0];
        CFG_MIN_REGION:   min_region   <= cfg_data;
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[8:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[8:0];
      endcase
    end
  end

  always_comb begin
    fw_x = XW'(frame_width);
    fh_x = XH'(frame_height);
    if (fw_x == '0) begin
      w_eff = XW'(1);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = fw_x;
    end
    if (fh_x == '0) begin
      h_eff = XH'(1);
    end else if (fh_x > XH'(MAX_HEIGHT)) begin
      h_eff = XH'(MAX_HEIGHT);
    end else begin
      h_eff = fh_x;
    end
    req.start       = start;
    req.cmd         = cmd;
    req.row         = row;
    req.col         = col;
    req.pixel_value = pixel_value;
    cfg.threshold   = threshold;
    cfg.min_region  = min_region;
  end

  trcl_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg          (cfg),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .busy         (busy),
    .done         (done),
    .label        (label),
    .region_count (region_count)
  );

  assign label_saturated = (region_count > 10'd255);

endmodule
`default_nettype wire

[rtl/trcl_checker.sv]
`default_nettype none
module trcl_checker
  import trcl_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] cmd,
  input wire logic       done,
  input wire logic [7:0] label,
  input wire logic [9:0] region_count,
  input wire logic       label_saturated
);

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_LOAD) |=> done)
    else $error("load transaction gave no result");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_READ) |=> ##1 done)
    else $error("read transaction gave no result");

  a_label_strobe: assert property (@(posedge clk) disable iff (rst)
    (label != 8'd0) |-> done)
    else $error("label shown without a result");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    ($past(!busy) && !($past(start) && $past(cmd) == CMD_RUN)) |-> $stable(region_count))
    else $error("region count changed outside a run");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    label_saturated == (region_count > 10'd255))
    else $error("saturation flag disagrees with region count");

endmodule

bind threshold_connected_region_labeling_top trcl_checker u_trcl_checker (.*);
`default_nettype wire

[dv/threshold_connected_region_labeling_top_test.sv]
`default_nettype none
module threshold_connected_region_labeling_top_test
  import trcl_pkg::*;
;

  localparam int MW = 256;
  localparam int NPIX = 65536;

  typedef struct {
    logic [1:0] op;
    logic [7:0] r;
    logic [7:0] c;
    logic [7:0] grey;
  } command_t;

  typedef struct {
    logic [7:0] label;
    logic [9:0] region_count;
    logic       label_saturated;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = CMD_NOP;
  logic [7:0]  row = '0;
  logic [7:0]  col = '0;
  logic [7:0]  pixel_value = '0;
  logic        done;
  logic [7:0]  label;
  logic [9:0]  region_count;
  logic        label_saturated;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  threshold_connected_region_labeling_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .row(row), .col(col),
    .pixel_value(pixel_value), .done(done), .label(label), .region_count(region_count),
    .label_saturated(label_saturated), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  command_t command_q[$];
  outcome_t outcome_q[$];
  bit       failed = 1'b0;
  int       idle_level = 1;
  int       gap = 0;

  // Predictor state.
  logic [7:0]  grey_thr = RST_THRESHOLD;
  logic [15:0] min_size = RST_MIN_REGION;
  logic [8:0]  cfg_w = RST_FRAME_WIDTH;
  logic [8:0]  cfg_h = RST_FRAME_HEIGHT;
  logic [7:0]  image_px[NPIX];
  logic [7:0]  label_px[NPIX];
  bit          trial_px[NPIX];
  bit          reject_px[NPIX];
  bit          loaded_px[NPIX];
  int          fill_stack[NPIX];
  int          found = 0;
  int          next_id = 1;

  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MW) return MW;
    return int'(v);
  endfunction

  function automatic void try_join(int from, int to, inout int sz);
    int a;
    int b;
    int d;
    a = image_px[from];
    b = image_px[to];
    d = (a > b) ? a - b : b - a;
    if (trial_px[to] || d > grey_thr) return;
    trial_px[to] = 1'b1;
    fill_stack[sz] = to;
    sz++;
  endfunction

  function automatic void flood_region(int seed, int w, int h);
    int head;
    int sz;
    int p;
    int r;
    int c;
    head = 0;
    trial_px[seed] = 1'b1;
    fill_stack[0] = seed;
    sz = 1;
    while (head < sz) begin
      p = fill_stack[head];
      r = p / MW;
      c = p % MW;
      head++;
      if (r > 0) try_join(p, p - MW, sz);
      if (r + 1 < h) try_join(p, p + MW, sz);
      if (c > 0) try_join(p, p - 1, sz);
      if (c + 1 < w) try_join(p, p + 1, sz);
    end
    if (sz > min_size) begin
      for (int k = 0; k < sz; k++) label_px[fill_stack[k]] = next_id[7:0];
      if (found < 1023) found++;
      if (next_id < 255) next_id++;
    end else begin
      for (int k = 0; k < sz; k++) reject_px[fill_stack[k]] = 1'b1;
    end
    for (int k = 0; k < sz; k++) trial_px[fill_stack[k]] = 1'b0;
  endfunction

  function automatic void label_frame();
    int w;
    int h;
    w = eff_dim(cfg_w);
    h = eff_dim(cfg_h);
    for (int i = 0; i < NPIX; i++) begin
      label_px[i] = '0;
      reject_px[i] = 1'b0;
      trial_px[i] = 1'b0;
    end
    found = 0;
    next_id = 1;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (label_px[r * MW + c] == 0 && !reject_px[r * MW + c]) flood_region(r * MW + c, w, h);
  endfunction

  function automatic outcome_t predict_outcome(logic [1:0] op, logic [7:0] r, logic [7:0] c,
                                               logic [7:0] grey);
    outcome_t o;
    o.label = '0;
    case (op)
      CMD_LOAD: image_px[int'(r) * MW + int'(c)] = grey;
      CMD_RUN: label_frame();
      CMD_READ: begin
        if (r < eff_dim(cfg_h) && c < eff_dim(cfg_w)) o.label = label_px[int'(r) * MW + int'(c)];
      end
      default: ;
    endcase
    o.region_count = found[9:0];
    o.label_saturated = (found > 255);
    return o;
  endfunction

  function automatic int pick_gap();
    int x;
    if (idle_level == 0) return 0;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    command_t it;
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      if (start && !busy) outcome_q.push_back(predict_outcome(cmd, row, col, pixel_value));
      if (start && busy) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (command_q.size() > 0) begin
        it = command_q.pop_front();
        cmd <= it.op;
        row <= it.r;
        col <= it.c;
        pixel_value <= it.grey;
        start <= 1'b1;
        gap <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result: label %0d region_count %0d", label, region_count);
        failed = 1'b1;
      end else begin
        e = outcome_q.pop_front();
        if (label !== e.label) begin
          $error("label: expected %0d, actual %0d", e.label, label);
          failed = 1'b1;
        end
        if (region_count !== e.region_count) begin
          $error("region_count: expected %0d, actual %0d", e.region_count, region_count);
          failed = 1'b1;
        end
        if (label_saturated !== e.label_saturated) begin
          $error("label_saturated: expected %0d, actual %0d", e.label_saturated,
                 label_saturated);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic push_command(logic [1:0] op, int r, int c, int grey);
    command_t it;
    it.op = op;
    it.r = r[7:0];
    it.c = c[7:0];
    it.grey = grey[7:0];
    if (op == CMD_LOAD) loaded_px[r * MW + c] = 1'b1;
    command_q.push_back(it);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    case (idx)
      CFG_THRESHOLD: grey_thr = value[7:0];
      CFG_MIN_REGION: min_size = value[15:0];
      CFG_FRAME_WIDTH: cfg_w = value[8:0];
      default: cfg_h = value[8:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (command_q.size() > 0 || start || outcome_q.size() > 0 || busy) @(posedge clk);
  endtask

  // Frame patterns: 0 random, 1 blocks of similar grey, 2 checkerboard.
  task automatic load_frame(int pattern);
    int w;
    int h;
    int v;
    w = eff_dim(cfg_w);
    h = eff_dim(cfg_h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (loaded_px[r * MW + c] && $urandom_range(0, 99) < 70) continue;
        case (pattern)
          0: v = $urandom_range(0, 255);
          1: v = ((r / 3 + c / 4) % 3) * 90 + $urandom_range(0, 3);
          default: v = ((r + c) % 2) ? 255 : 0;
        endcase
        push_command(CMD_LOAD, r, c, v);
      end
  endtask

  task automatic add_reads(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80)
        push_command(CMD_READ, $urandom_range(0, eff_dim(cfg_h) - 1),
                     $urandom_range(0, eff_dim(cfg_w) - 1), $urandom_range(0, 255));
      else
        push_command(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
    end
  endtask

  task automatic run_phase(int w, int h, int thr, int minr, int pattern, int idle);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_MIN_REGION, minr);
    idle_level = idle;
    add_reads(5);
    load_frame(pattern);
    for (int i = 0; i < 6; i++)
      push_command($urandom_range(0, 1) ? CMD_NOP : CMD_LOAD, $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    push_command(CMD_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
    add_reads(20);
    push_command(CMD_NOP, 0, 0, 0);
  endtask

  initial begin
    foreach (label_px[i]) label_px[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_reg(CFG_FRAME_WIDTH, 4);
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_THRESHOLD, 3);
    write_reg(CFG_MIN_REGION, 1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) push_command(CMD_LOAD, r, c, (c < 2) ? 0 : 255);
    push_command(CMD_LOAD, 2, 3, 252);
    push_command(CMD_LOAD, 255, 255, 255);
    push_command(CMD_NOP, 255, 255, 255);
    push_command(CMD_READ, 0, 0, 0);
    push_command(CMD_RUN, 0, 0, 0);
    push_command(CMD_READ, 0, 0, 0);
    push_command(CMD_READ, 2, 3, 0);
    push_command(CMD_READ, 3, 0, 0);
    push_command(CMD_READ, 0, 4, 0);
    push_command(CMD_READ, 255, 255, 255);
    push_command(CMD_NOP, 0, 0, 0);

    run_phase(256, 2, 0, 0, 2, 1);
    run_phase(8, 6, 3, 4, 1, 1);
    run_phase(0, 5, 255, 0, 0, 0);
    run_phase(511, 1, 10, 2, 1, 1);
    run_phase(1, 256, 0, 65535, 0, 1);
    run_phase(16, 16, 40, 10, 1, 0);
    run_phase(12, 9, 1, 0, 0, 1);
    run_phase(20, 10, 255, 199, 0, 1);
    run_phase(256, 2, 128, 3, 1, 1);
    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed && outcome_q.size() == 0) begin
      $display("threshold_connected_region_labeling_top regression: pass");
    end else begin
      $display("threshold_connected_region_labeling_top regression: fail");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("threshold_connected_region_labeling_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
